/* rtl/sess_pkg.sv */
package sess_pkg;

  // table geometry defaults
  localparam int SESS_SLOTS        = 8;
  localparam int SESS_TOKEN_DIGITS = 16;

  // field widths fixed by the interface
  localparam int TIME_W  = 64;
  localparam int TOKEN_W = 64;
  localparam int GEN_W   = 32;
  localparam int SLOT_W  = 3;
  localparam int LIMIT_W = 63;
  localparam int CFG_INDEX_W = 2;

  // limit register reset values in microseconds
  localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RESET     = 63'd900000000;
  localparam logic [LIMIT_W-1:0] ABSOLUTE_LIMIT_RESET = 63'd86400000000;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ABSOLUTE_LIMIT = 2'd1;

  // command codes
  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_CHECK  = 2'd2,
    CMD_REVOKE = 2'd3
  } sess_cmd_t;

  // one input request
  typedef struct packed {
    sess_cmd_t                 cmd;
    logic signed [TIME_W-1:0]  now;
    logic [TOKEN_W-1:0]        token;
    logic [TOKEN_W-1:0]        csrf;
    logic [SLOT_W-1:0]         slot;
    logic [GEN_W-1:0]          expected_generation;
    logic                      touch;
  } sess_req_t;

  // one result
  typedef struct packed {
    logic                ok;
    logic [SLOT_W-1:0]   result_slot;
    logic [GEN_W-1:0]    result_generation;
    logic [TOKEN_W-1:0]  result_csrf;
  } sess_rsp_t;

  // expiry limits broadcast to every slot cell
  typedef struct packed {
    logic [LIMIT_W-1:0] idle;
    logic [LIMIT_W-1:0] absolute;
  } sess_limits_t;

  // request travelling down the cell chain with its partial result
  typedef struct packed {
    logic              valid;
    logic              done;
    sess_req_t         req;
    logic [GEN_W-1:0]  new_gen;
    sess_rsp_t         rsp;
  } sess_pkt_t;

endpackage

/* rtl/sess_cell.sv */
module sess_cell #(
  parameter int CELL_INDEX = 0,
  parameter int TOKEN_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  sess_pkg::sess_limits_t limits,
  input  sess_pkg::sess_pkt_t   pkt_in,
  output sess_pkg::sess_pkt_t   pkt_out
);
  import sess_pkg::*;

  // slot contents
  logic [TOKEN_BITS-1:0]    slot_token, slot_token_next;
  logic [TOKEN_BITS-1:0]    slot_csrf, slot_csrf_next;
  logic [GEN_W-1:0]         slot_generation, slot_generation_next;
  logic signed [TIME_W-1:0] slot_created, slot_created_next;
  logic signed [TIME_W-1:0] slot_last_seen, slot_last_seen_next;

  logic [TIME_W-1:0] idle_age;
  logic [TIME_W-1:0] total_age;
  logic              occupied;
  logic              expired;
  logic              token_hit;
  logic              slot_hit;
  sess_pkt_t         pkt_next;

  // expiry test against the request time
  always_comb begin
    idle_age  = TIME_W'(pkt_in.req.now - slot_last_seen);
    total_age = TIME_W'(pkt_in.req.now - slot_created);
    occupied  = (slot_generation != '0);
    expired   = (pkt_in.req.now < slot_last_seen) || (pkt_in.req.now < slot_created) ||
                (idle_age >= {1'b0, limits.idle}) || (total_age >= {1'b0, limits.absolute});
    token_hit = (pkt_in.req.token[TOKEN_BITS-1:0] == slot_token);
    slot_hit  = ({{(32-SLOT_W){1'b0}}, pkt_in.req.slot} == 32'(CELL_INDEX));
  end

  // per-command slot update and result fill
  always_comb begin
    slot_token_next      = slot_token;
    slot_csrf_next       = slot_csrf;
    slot_generation_next = slot_generation;
    slot_created_next    = slot_created;
    slot_last_seen_next  = slot_last_seen;
    pkt_next             = pkt_in;
    if (pkt_in.valid && !pkt_in.done) begin
      unique case (pkt_in.req.cmd)
        CMD_CREATE: begin
          // first slot that is empty or expired is taken
          if (!occupied || expired) begin
            slot_token_next      = pkt_in.req.token[TOKEN_BITS-1:0];
            slot_csrf_next       = pkt_in.req.csrf[TOKEN_BITS-1:0];
            slot_generation_next = pkt_in.new_gen;
            slot_created_next    = pkt_in.req.now;
            slot_last_seen_next  = pkt_in.req.now;
            pkt_next.done                  = 1'b1;
            pkt_next.rsp.ok                = 1'b1;
            pkt_next.rsp.result_slot       = SLOT_W'(CELL_INDEX);
            pkt_next.rsp.result_generation = pkt_in.new_gen;
            pkt_next.rsp.result_csrf       = TOKEN_W'(pkt_in.req.csrf[TOKEN_BITS-1:0]);
          end
        end
        CMD_FIND: begin
          // matching expired slot is dropped and the scan goes on
          if (occupied && token_hit) begin
            if (expired) begin
              slot_generation_next = '0;
            end else begin
              slot_last_seen_next            = pkt_in.req.now;
              pkt_next.done                  = 1'b1;
              pkt_next.rsp.ok                = 1'b1;
              pkt_next.rsp.result_slot       = SLOT_W'(CELL_INDEX);
              pkt_next.rsp.result_generation = slot_generation;
              pkt_next.rsp.result_csrf       = TOKEN_W'(slot_csrf);
            end
          end
        end
        CMD_CHECK: begin
          if (slot_hit) begin
            pkt_next.done = 1'b1;
            if (occupied && slot_generation == pkt_in.req.expected_generation) begin
              if (expired) begin
                slot_generation_next = '0;
              end else begin
                if (pkt_in.req.touch) begin
                  slot_last_seen_next = pkt_in.req.now;
                end
                pkt_next.rsp.ok                = 1'b1;
                pkt_next.rsp.result_slot       = SLOT_W'(CELL_INDEX);
                pkt_next.rsp.result_generation = slot_generation;
                pkt_next.rsp.result_csrf       = TOKEN_W'(slot_csrf);
              end
            end
          end
        end
        CMD_REVOKE: begin
          if (slot_hit) begin
            slot_generation_next = '0;
            pkt_next.done        = 1'b1;
            pkt_next.rsp.ok      = 1'b1;
          end
        end
        default: begin
          pkt_next = pkt_in;
        end
      endcase
    end
  end

  // slot storage; a zero generation marks the slot empty
  always_ff @(posedge clk) begin
    slot_token     <= slot_token_next;
    slot_csrf      <= slot_csrf_next;
    slot_created   <= slot_created_next;
    slot_last_seen <= slot_last_seen_next;
    if (rst) begin
      slot_generation <= '0;
    end else begin
      slot_generation <= slot_generation_next;
    end
  end

  // hand the request to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      pkt_out <= '0;
    end else begin
      pkt_out <= pkt_next;
    end
  end

endmodule

/* rtl/session_table_with_expiry_top.sv */
// channel | direction | handshake             | payload
// req     | in        | req_valid / req_ready | sess_req_t: cmd, now, token, csrf, slot, ...
// rsp     | out       | rsp_valid / rsp_ready | sess_rsp_t: ok, result_slot, ...
// cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data (limit registers)
//
// A request walks the row of slot cells, one cell per cycle, and its result is registered
// at the end of the row, where it waits until it is taken.
// One request is in the table at a time; the next is taken once the result is taken.
// Reset empties every slot, zeroes the generation counter and loads the default limits.
// Configuration writes are taken in any cycle and are meant for idle periods.
module session_table_with_expiry_top #(
  parameter int SLOTS        = sess_pkg::SESS_SLOTS,
  parameter int TOKEN_DIGITS = sess_pkg::SESS_TOKEN_DIGITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  sess_pkg::sess_req_t                 req,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output sess_pkg::sess_rsp_t                 rsp,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sess_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sess_pkg::TIME_W-1:0]         cfg_data
);
  import sess_pkg::*;

  localparam int TOKEN_BITS = 4 * TOKEN_DIGITS;

  logic              busy;
  logic [GEN_W-1:0]  gen_counter;
  logic [GEN_W-1:0]  new_gen;
  sess_limits_t      limits;
  sess_pkt_t         entry;
  sess_pkt_t         chain [SLOTS+1];
  logic              req_fire;
  logic              rsp_fire;

  assign req_ready = !busy;
  assign cfg_ready = 1'b1;
  assign req_fire  = req_valid && req_ready;
  assign rsp_fire  = rsp_valid && rsp_ready;

  // next generation skips zero
  assign new_gen = (gen_counter == '1) ? GEN_W'(1) : gen_counter + GEN_W'(1);

  // request enters the first cell; create with negative time is settled here
  always_comb begin
    entry         = '0;
    entry.valid   = req_fire;
    entry.req     = req;
    entry.new_gen = new_gen;
    entry.done    = (req.cmd == CMD_CREATE) && req.now[TIME_W-1];
  end

  assign chain[0] = entry;

  // row of slot cells
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sess_cell #(
      .CELL_INDEX (g),
      .TOKEN_BITS (TOKEN_BITS)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .limits  (limits),
      .pkt_in  (chain[g]),
      .pkt_out (chain[g+1])
    );
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limits.idle     <= IDLE_LIMIT_RESET;
      limits.absolute <= ABSOLUTE_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_IDLE_LIMIT) begin
        limits.idle <= cfg_data[LIMIT_W-1:0];
      end
      if (cfg_index == REG_ABSOLUTE_LIMIT) begin
        limits.absolute <= cfg_data[LIMIT_W-1:0];
      end
    end
  end

  // request tracking, result register and generation counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      rsp_valid   <= 1'b0;
      gen_counter <= '0;
    end else begin
      if (req_fire) begin
        busy <= 1'b1;
      end
      if (chain[SLOTS].valid) begin
        rsp_valid <= 1'b1;
        if (chain[SLOTS].req.cmd == CMD_CREATE && chain[SLOTS].rsp.ok) begin
          gen_counter <= chain[SLOTS].new_gen;
        end
      end else if (rsp_fire) begin
        rsp_valid <= 1'b0;
        busy      <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (chain[SLOTS].valid) begin
      rsp <= chain[SLOTS].rsp;
    end
  end

  // checks
  a_rsp_needs_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> busy)
    else $error("result pending without a request in flight");

  a_exit_into_empty: assert property (@(posedge clk) disable iff (rst)
    chain[SLOTS].valid |-> !rsp_valid)
    else $error("chain result would overwrite a pending result");

  a_gen_never_zero: assert property (@(posedge clk) disable iff (rst)
    gen_counter != '0 |=> gen_counter != '0)
    else $error("generation counter returned to zero");

  a_accept_when_drained: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (busy && !rsp_valid))
    else $error("request accepted while the table was not drained");

endmodule

/* test/session_table_with_expiry_top_tb.sv */
`timescale 1ns / 1ps

module session_table_with_expiry_top_tb;
  import sess_pkg::*;

  localparam int TABLE_LATENCY = SESS_SLOTS + 2;
  localparam int HOLD_CYCLES   = 300;
  localparam logic [63:0] SPAN_CAP  = 64'd1_000_000_000;
  localparam logic [63:0] LIMIT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] DIGIT_MASK = (SESS_TOKEN_DIGITS >= 16) ? {64{1'b1}} :
                                       ((64'd1 << (4 * SESS_TOKEN_DIGITS)) - 64'd1);

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   req_valid = 1'b0;
  logic                   req_ready;
  sess_req_t              req = '0;
  logic                   rsp_valid;
  logic                   rsp_ready = 1'b0;
  sess_rsp_t              rsp;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]      cfg_data = '0;

  // predicted table contents and limits
  logic [63:0]        tab_token [SESS_SLOTS];
  logic [63:0]        tab_csrf  [SESS_SLOTS];
  logic [GEN_W-1:0]   tab_gen   [SESS_SLOTS];
  logic [63:0]        tab_born  [SESS_SLOTS];
  logic [63:0]        tab_seen  [SESS_SLOTS];
  logic [GEN_W-1:0]   gen_ctr;
  logic [LIMIT_W-1:0] idle_lim;
  logic [LIMIT_W-1:0] abs_lim;

  // responses still owed by the table, oldest first
  sess_rsp_t awaited_rsp [$];

  // stimulus state
  logic [63:0] sim_now = 64'd10_000;
  logic [63:0] token_pool [4];
  bit          steady_flow = 1'b0;
  int          hold_asked = 0;
  int          hold_served = 0;
  int          hold_left = 0;

  // run statistics
  int error_count = 0;
  int rsp_seen = 0;
  int ok_count = 0;
  int limit_sets = 0;
  int cmd_count [4] = '{0, 0, 0, 0};

  session_table_with_expiry_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("Timeout: session table stopped making progress");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic note_error(input string what);
    error_count++;
    if (error_count <= 10) $display("ERROR @%0t: %s", $time, what);
  endtask

  // ---------------- session table predictor ----------------

  function automatic void clear_session(input int i);
    tab_token[i] = '0;
    tab_csrf[i]  = '0;
    tab_gen[i]   = '0;
    tab_born[i]  = '0;
    tab_seen[i]  = '0;
  endfunction

  function automatic void reset_table_model();
    for (int i = 0; i < SESS_SLOTS; i++) clear_session(i);
    gen_ctr  = '0;
    idle_lim = IDLE_LIMIT_RESET;
    abs_lim  = ABSOLUTE_LIMIT_RESET;
  endfunction

  // time runs backwards, or idle or age limit reached
  function automatic bit session_expired(input int i, input logic [63:0] t);
    return ($signed(t) < $signed(tab_seen[i])) || ($signed(t) < $signed(tab_born[i])) ||
           ((t - tab_seen[i]) >= {1'b0, idle_lim}) ||
           ((t - tab_born[i]) >= {1'b0, abs_lim});
  endfunction

  // liveness against a generation; an expired slot is cleared on the visit
  function automatic bit session_live(input int i, input logic [GEN_W-1:0] gen,
                                      input logic [63:0] t, input bit touch);
    if (tab_gen[i] == '0 || tab_gen[i] != gen) return 1'b0;
    if (session_expired(i, t)) begin
      clear_session(i);
      return 1'b0;
    end
    if (touch) tab_seen[i] = t;
    return 1'b1;
  endfunction

  function automatic sess_rsp_t session_hit(input int i);
    sess_rsp_t res;
    res.ok                = 1'b1;
    res.result_slot       = SLOT_W'(i);
    res.result_generation = tab_gen[i];
    res.result_csrf       = tab_csrf[i];
    return res;
  endfunction

  // apply one request to the model and return the response it should produce
  function automatic sess_rsp_t apply_session_cmd(input sess_req_t r);
    sess_rsp_t   res;
    logic [63:0] t;
    logic [63:0] tok;
    logic [63:0] xsrf;
    bit          placed;
    res    = '0;
    t      = r.now;
    tok    = r.token & DIGIT_MASK;
    xsrf   = r.csrf & DIGIT_MASK;
    placed = 1'b0;
    case (r.cmd)
      CMD_CREATE: begin
        // negative time never creates
        if (!t[63]) begin
          for (int i = 0; i < SESS_SLOTS; i++) begin
            if (!placed) begin
              if (!session_live(i, tab_gen[i], t, 1'b0)) begin
                clear_session(i);
                gen_ctr = gen_ctr + 1'b1;
                if (gen_ctr == '0) gen_ctr = gen_ctr + 1'b1;
                tab_token[i] = tok;
                tab_csrf[i]  = xsrf;
                tab_gen[i]   = gen_ctr;
                tab_born[i]  = t;
                tab_seen[i]  = t;
                res    = session_hit(i);
                placed = 1'b1;
              end
            end
          end
        end
      end
      CMD_FIND: begin
        // only token matches are visited; an expired match is cleared and skipped
        for (int i = 0; i < SESS_SLOTS; i++) begin
          if (!placed && tab_gen[i] != '0 && tab_token[i] == tok) begin
            if (session_live(i, tab_gen[i], t, 1'b1)) begin
              res    = session_hit(i);
              placed = 1'b1;
            end
          end
        end
      end
      CMD_CHECK: begin
        if (int'(r.slot) < SESS_SLOTS) begin
          if (session_live(int'(r.slot), r.expected_generation, t, r.touch))
            res = session_hit(int'(r.slot));
        end
      end
      default: begin
        if (int'(r.slot) < SESS_SLOTS) begin
          clear_session(int'(r.slot));
          res.ok = 1'b1;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------- drivers ----------------

  // offer one request, predict its response at the accepting edge
  task automatic send_request(input sess_req_t r);
    sess_rsp_t want;
    if (!steady_flow && $urandom_range(0, 99) < 37) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    want = apply_session_cmd(r);
    awaited_rsp.push_back(want);
    cmd_count[int'(r.cmd)]++;
    ok_count += want.ok;
  endtask

  // stop offering and wait until every owed response has come back
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // one register write; valid stays up for a following write
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_IDLE_LIMIT) idle_lim = data[LIMIT_W-1:0];
    else if (idx == REG_ABSOLUTE_LIMIT) abs_lim = data[LIMIT_W-1:0];
  endtask

  // both limits, only while the table is idle
  task automatic write_limits(input logic [63:0] idle_val, input logic [63:0] abs_val);
    cfg_write(REG_IDLE_LIMIT, idle_val);
    cfg_write(REG_ABSOLUTE_LIMIT, abs_val);
    cfg_valid <= 1'b0;
    limit_sets++;
  endtask

  // response side: random stalls, or one long hold-off when asked
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (steady_flow) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= 37);
    end
  end

  // compare each response with the oldest prediction
  always @(posedge clk) begin : check_responses
    sess_rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      rsp_seen++;
      if (awaited_rsp.size() == 0) begin
        note_error($sformatf("response with nothing pending: ok=%0b slot=%0d gen=%0d csrf=%h",
                             rsp.ok, rsp.result_slot, rsp.result_generation, rsp.result_csrf));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.ok !== want.ok || rsp.result_slot !== want.result_slot ||
            rsp.result_generation !== want.result_generation ||
            rsp.result_csrf !== want.result_csrf)
          note_error($sformatf({"response %0d: expected ok=%0b slot=%0d gen=%0d csrf=%h, ",
                                "got ok=%0b slot=%0d gen=%0d csrf=%h"}, rsp_seen,
                               want.ok, want.result_slot, want.result_generation,
                               want.result_csrf, rsp.ok, rsp.result_slot,
                               rsp.result_generation, rsp.result_csrf));
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic sess_req_t make_req(input sess_cmd_t cmd, input logic [63:0] t,
                                         input logic [63:0] tok, input logic [63:0] xsrf,
                                         input int idx, input logic [GEN_W-1:0] gen,
                                         input bit touch);
    sess_req_t r;
    r.cmd                 = cmd;
    r.now                 = t;
    r.token               = tok;
    r.csrf                = xsrf;
    r.slot                = SLOT_W'(idx);
    r.expected_generation = gen;
    r.touch               = touch;
    return r;
  endfunction

  // mostly plausible session traffic on a forward clock, some pure noise
  function automatic sess_req_t next_session_request();
    sess_req_t   r;
    logic [63:0] span;
    logic [63:0] step;
    int          pick;
    r.cmd                 = sess_cmd_t'($urandom_range(0, 3));
    r.now                 = {$urandom, $urandom};
    r.token               = {$urandom, $urandom};
    r.csrf                = {$urandom, $urandom};
    r.slot                = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
    r.expected_generation = $urandom;
    r.touch               = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 12) return r;

    // time steps sized to the idle limit, with rare jumps past it
    span = {1'b0, idle_lim} / 64'd2 + 64'd1;
    if (span > SPAN_CAP) span = SPAN_CAP;
    step = {$urandom, $urandom} % (span + 64'd1);
    if ($urandom_range(0, 99) < 6) step = step * 64'd3;
    sim_now = sim_now + step;
    r.now   = sim_now;
    if ($urandom_range(0, 99) < 4) r.now = sim_now - 64'($urandom_range(1, 3));

    // command mix leans on create so the table fills
    pick = $urandom_range(0, 99);
    if (pick < 35) r.cmd = CMD_CREATE;
    else if (pick < 60) r.cmd = CMD_FIND;
    else if (pick < 90) r.cmd = CMD_CHECK;
    else r.cmd = CMD_REVOKE;
    if ($urandom_range(0, 99) < 85) r.token = token_pool[$urandom_range(0, 3)];
    pick = $urandom_range(0, 99);
    if (pick < 70) r.expected_generation = tab_gen[r.slot];
    else if (pick < 85) r.expected_generation = tab_gen[r.slot] + 1'b1;
    return r;
  endfunction

  // reset limits, idle boundary, negative create time
  task automatic test_reset_limits();
    send_request(make_req(CMD_CREATE, 64'd0, '1, '1, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, 64'd899_999_999, '0, '0, 0, tab_gen[0], 1'b0));
    send_request(make_req(CMD_CHECK, 64'd900_000_000, '0, '0, 0, tab_gen[0], 1'b0));
    send_request(make_req(CMD_CREATE, 64'h8000_0000_0000_0000, '1, '1, 0, 0, 1'b0));
  endtask

  // duplicate tokens, misses, stale generation, time going backwards
  task automatic test_token_lookup();
    wait_drained();
    write_limits(64'd100, 64'd1000);
    send_request(make_req(CMD_CREATE, 64'd1000, '0, '0, 0, 0, 1'b0));
    send_request(make_req(CMD_CREATE, 64'd1010, '0, 64'hA5A5_A5A5_A5A5_A5A5, 0, 0, 1'b0));
    send_request(make_req(CMD_FIND, 64'd1105, '0, '0, 0, 0, 1'b0));
    send_request(make_req(CMD_FIND, 64'd1106, 64'h0123_4567_89AB_CDEF, '0, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, 64'd1106, '0, '0, 1, tab_gen[1] + 1'b1, 1'b1));
    send_request(make_req(CMD_CHECK, 64'd1100, '0, '0, 1, tab_gen[1], 1'b1));
  endtask

  // full table refuses create, expired slot is reused first, revoke
  task automatic test_table_full();
    for (int i = 0; i < SESS_SLOTS; i++)
      send_request(make_req(CMD_CREATE, 64'd2000 + 64'(i), 64'(i), 64'(i + 16), 0, 0, 1'b0));
    send_request(make_req(CMD_CREATE, 64'd2008, 64'd99, 64'd99, 0, 0, 1'b0));
    send_request(make_req(CMD_CREATE, 64'd2100, 64'd77, 64'd77, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, 64'd2105, '0, '0, 7, tab_gen[7], 1'b1));
    send_request(make_req(CMD_REVOKE, 64'd2105, '0, '0, 3, 0, 1'b0));
  endtask

  // one-microsecond, full-range and masked-to-zero limits
  task automatic test_limit_extremes();
    wait_drained();
    write_limits(LIMIT_MAX, 64'd1);
    send_request(make_req(CMD_CREATE, 64'd5, 64'd5, 64'd5, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, 64'd5, '0, '0, 0, tab_gen[0], 1'b1));
    send_request(make_req(CMD_CHECK, 64'd6, '0, '0, 0, tab_gen[0], 1'b0));
    wait_drained();
    write_limits(LIMIT_MAX, LIMIT_MAX);
    send_request(make_req(CMD_CREATE, 64'd0, 64'd6, 64'd6, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, LIMIT_MAX - 64'd1, '0, '0, 0, tab_gen[0], 1'b0));
    send_request(make_req(CMD_CHECK, LIMIT_MAX, '0, '0, 0, tab_gen[0], 1'b0));
    wait_drained();
    // top data bit is dropped, leaving an idle limit of zero
    write_limits(64'h8000_0000_0000_0000, '1);
    send_request(make_req(CMD_CREATE, 64'd0, 64'd7, 64'd7, 0, 0, 1'b0));
    send_request(make_req(CMD_CHECK, 64'd0, '0, '0, 0, tab_gen[0], 1'b0));
    send_request(make_req(CMD_CREATE, LIMIT_MAX, 64'd8, 64'd8, 0, 0, 1'b0));
  endtask

  // random traffic under one pair of limits
  task automatic test_random_traffic(input logic [63:0] idle_val, input logic [63:0] abs_val,
                                     input int count);
    wait_drained();
    write_limits(idle_val, abs_val);
    for (int k = 0; k < 3; k++) token_pool[k] = {$urandom, $urandom};
    token_pool[3] = $urandom_range(0, 1) ? '0 : '1;
    repeat (count) send_request(next_session_request());
  endtask

  // long response hold-off while requests keep coming, then a full pause
  task automatic test_backpressure();
    steady_flow = 1'b1;
    hold_asked  = hold_asked + 1;
    repeat (40) send_request(next_session_request());
    wait_drained();
    steady_flow = 1'b0;
  endtask

  // ---------------- sequence ----------------

  initial begin
    reset_table_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_limits();
    test_token_lookup();
    test_table_full();
    test_limit_extremes();
    test_random_traffic(64'(IDLE_LIMIT_RESET), 64'(ABSOLUTE_LIMIT_RESET), 250);
    test_random_traffic(64'd200, 64'd3000, 300);
    test_backpressure();
    test_random_traffic(64'd1, LIMIT_MAX, 150);
    test_random_traffic(64'($urandom_range(1, 5000)), 64'($urandom_range(1, 50000)), 300);

    // let any stray response show up
    wait_drained();
    repeat (2 * TABLE_LATENCY) @(posedge clk);
    if (awaited_rsp.size() != 0)
      note_error($sformatf("%0d responses never arrived", awaited_rsp.size()));

    $display("Covered %0d requests (%0d create, %0d find, %0d check, %0d revoke), %0d ok",
             cmd_count[0] + cmd_count[1] + cmd_count[2] + cmd_count[3], cmd_count[0],
             cmd_count[1], cmd_count[2], cmd_count[3], ok_count);
    $display("%0d limit settings incl. extremes; one %0d-cycle response stall; %0d errors",
             limit_sets, HOLD_CYCLES, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* session_table_with_expiry_top.f */
rtl/sess_pkg.sv
rtl/sess_cell.sv
rtl/session_table_with_expiry_top.sv
test/session_table_with_expiry_top_tb.sv
